// File: sv/sha_pkg.sv
// Shared constants, tables and command type for the SHA-256 stream hasher.
`default_nettype none

package sha_pkg;

   localparam int unsigned MSG_BITS = 512;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [1:0] LAST_WORD = 2'd3;
   localparam logic KIND_APPEND = 1'b0;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef struct packed {
      logic       push;       // shift one byte into the message window
      logic [7:0] push_byte;
      logic       start;      // load working variables from chain state
      logic       round;      // run one compression round
      logic [5:0] round_idx;
      logic       fold;       // add working variables into chain state
      logic       init;       // chain state back to the initial vector
      logic [1:0] word_sel;   // digest word on the result port
   } sha_cmd_type;

endpackage

`default_nettype wire

// File: sv/sha_datapath.sv
// SHA-256 datapath: message window, working variables and chain state.
`default_nettype none

module sha_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sha_pkg::sha_cmd_type cmd,
   output logic [63:0]              digest_word
);
   import sha_pkg::*;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [MSG_BITS-1:0] msg_ff, msg_in;
   logic [31:0]         h_ff [8];
   logic [31:0]         h_in [8];
   logic [31:0]         s_ff [8];
   logic [31:0]         s_in [8];

   logic [31:0] win [16];
   logic [31:0] w_new, sg0, sg1, t1, t2, ch, maj, bs0, bs1;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win[i] = msg_ff[MSG_BITS-1-32*i -: 32];
      end
      // window slot 0 holds W[t]; slot 15 receives W[t+16]
      sg0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
      sg1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
      w_new = win[0] + sg0 + win[9] + sg1;

      bs1 = rotr(s_ff[4], 6) ^ rotr(s_ff[4], 11) ^ rotr(s_ff[4], 25);
      ch = (s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]);
      t1 = s_ff[7] + bs1 + ch + ROUND_K[cmd.round_idx] + win[0];
      bs0 = rotr(s_ff[0], 2) ^ rotr(s_ff[0], 13) ^ rotr(s_ff[0], 22);
      maj = (s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]);
      t2 = bs0 + maj;

      msg_in = msg_ff;
      s_in = s_ff;
      h_in = h_ff;

      if (cmd.push) begin
         msg_in = {msg_ff[MSG_BITS-9:0], cmd.push_byte};
      end else if (cmd.round) begin
         msg_in = {msg_ff[MSG_BITS-33:0], w_new};
      end

      if (cmd.start) begin
         s_in = h_ff;
      end else if (cmd.round) begin
         s_in[7] = s_ff[6];
         s_in[6] = s_ff[5];
         s_in[5] = s_ff[4];
         s_in[4] = s_ff[3] + t1;
         s_in[3] = s_ff[2];
         s_in[2] = s_ff[1];
         s_in[1] = s_ff[0];
         s_in[0] = t1 + t2;
      end

      if (cmd.init) begin
         h_in = INIT_HASH;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + s_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      s_ff <= s_in;
      if (reset) begin
         h_ff <= INIT_HASH;
      end else begin
         h_ff <= h_in;
      end
   end

   assign digest_word = {h_ff[{cmd.word_sel, 1'b0}], h_ff[{cmd.word_sel, 1'b1}]};

endmodule

`default_nettype wire

// File: sv/sha_ctrl.sv
// SHA-256 controller: handshakes, byte counting, padding and round sequencing.
`default_nettype none

module sha_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           req_kind,
   input  wire logic [7:0]     req_data_byte,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [1:0]          rsp_word_index,
   output logic                rsp_last,
   output sha_pkg::sha_cmd_type cmd
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_MARK, PH_ZERO, PH_LEN
   } phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic        padding_ff, padding_in;
   logic        done_ff, done_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      len_in = len_ff;
      round_in = round_ff;
      padding_in = padding_ff;
      done_in = done_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff;

      cmd = '0;
      cmd.round_idx = round_ff;
      cmd.word_sel = idx_ff;
      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_APPEND) begin
                  cmd.push = 1'b1;
                  cmd.push_byte = req_data_byte;
                  total_in = total_ff + 64'd1;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == LAST_FILL) begin
                     cmd.start = 1'b1;
                     round_in = '0;
                     state_in = ST_ROUND;
                  end
               end else begin
                  len_in = {total_ff[60:0], 3'b000};
                  phase_in = PH_MARK;
                  padding_in = 1'b1;
                  done_in = 1'b0;
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (done_ff) begin
               idx_in = '0;
               rsp_valid_in = 1'b1;
               state_in = ST_EMIT;
            end else if (padding_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            fill_in = fill_ff + 6'd1;
            case (phase_ff)
               PH_MARK: begin
                  cmd.push_byte = PAD_BYTE;
                  phase_in = (fill_ff == LEN_POS - 6'd1) ? PH_LEN : PH_ZERO;
               end
               PH_ZERO: begin
                  cmd.push_byte = 8'h00;
                  if (fill_ff == LEN_POS - 6'd1) begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  // bit length goes out most significant byte first
                  cmd.push_byte = len_ff[63:56];
                  len_in = {len_ff[55:0], 8'h00};
                  if (fill_ff == LAST_FILL) begin
                     done_in = 1'b1;
                  end
               end
               default: begin
                  cmd.push_byte = 8'h00;
               end
            endcase
            if (fill_ff == LAST_FILL) begin
               cmd.start = 1'b1;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == LAST_WORD) begin
                  cmd.init = 1'b1;
                  rsp_valid_in = 1'b0;
                  fill_in = '0;
                  total_in = '0;
                  padding_in = 1'b0;
                  done_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MARK;
         fill_ff <= '0;
         total_ff <= '0;
         round_ff <= '0;
         padding_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         round_ff <= round_in;
         padding_ff <= padding_in;
         done_ff <= done_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_last = (idx_ff == LAST_WORD);

endmodule

`default_nettype wire

// File: sv/sha256_stream_hasher.sv
// Append item: taken while idle; the item that completes a 64-byte block stalls the input
// while the single round unit runs its 64 rounds and then the chain-state add.
// Finish item: one pad byte per cycle (9 to 72 bytes), a compression after each full
// block (one or two), then four digest words, one per cycle when not stalled.
// Reset: chain state to the initial vector, byte and fill counters cleared;
// the message window is not cleared.
`default_nettype none

module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_last
);
   import sha_pkg::*;

   sha_cmd_type cmd;

   sha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .cmd            (cmd)
   );

   sha_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .digest_word (rsp_digest_word)
   );

endmodule

`default_nettype wire

// File: verif/sha256_digest_checker.sv
// Checker for the SHA-256 stream hasher: predicts digest words per item and compares them.
module sha256_digest_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_digest_word,
   input  wire logic [1:0]  rsp_word_index,
   input  wire logic        rsp_last,
   output int               mismatch_count,
   output int               words_pending,
   output int               words_checked
);
   import sha_pkg::*;

   localparam int BLOCK_BYTES = 64;

   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   digest_word_type digest_words_due [$];
   digest_word_type due;

   logic [31:0] chain [8];
   logic [7:0]  window [BLOCK_BYTES];
   int          fill;
   logic [63:0] bytes_seen;

   function automatic logic [31:0] ror32(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic compress_window();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] x, y, sg0, sg1, a, e, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {window[4*i], window[4*i+1], window[4*i+2], window[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         x = w[i-15];
         y = w[i-2];
         sg0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
         sg1 = ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10);
         w[i] = w[i-16] + sg0 + w[i-7] + sg1;
      end
      s = chain;
      for (int r = 0; r < 64; r++) begin
         e = s[4];
         a = s[0];
         t1 = s[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
              ((e & s[5]) ^ (~e & s[6])) + ROUND_K[r] + w[r];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
              ((a & s[1]) ^ (a & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6];
         s[6] = s[5];
         s[5] = s[4];
         s[4] = s[3] + t1;
         s[3] = s[2];
         s[2] = s[1];
         s[1] = s[0];
         s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain[i] = chain[i] + s[i];
   endtask

   task automatic absorb_byte(logic [7:0] b);
      window[fill] = b;
      fill++;
      if (fill == BLOCK_BYTES) begin
         compress_window();
         fill = 0;
      end
   endtask

   task automatic restart_message();
      chain = INIT_HASH;
      fill = 0;
      bytes_seen = '0;
   endtask

   task automatic update_hash(logic kind, logic [7:0] data);
      logic [63:0] bit_len;
      digest_word_type queued;
      if (kind == KIND_APPEND) begin
         bytes_seen++;
         absorb_byte(data);
      end else begin
         // data byte is a don't-care on finish
         bit_len = bytes_seen << 3;
         absorb_byte(PAD_BYTE);
         while (fill != LEN_POS)
            absorb_byte(8'h00);
         for (int i = 0; i < 8; i++)
            absorb_byte(bit_len[63 - 8*i -: 8]);
         for (int i = 0; i < 4; i++) begin
            queued.word = {chain[2*i], chain[2*i+1]};
            queued.index = 2'(i);
            queued.last = (i == 3);
            digest_words_due = {digest_words_due, queued};
         end
         restart_message();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         digest_words_due.delete();
         mismatch_count = 0;
         words_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_words_due.size() == 0) begin
               report_mismatch("unexpected digest word", rsp_digest_word, '0);
            end else begin
               due = digest_words_due.pop_front();
               words_checked++;
               if (rsp_digest_word !== due.word)
                  report_mismatch("digest_word", rsp_digest_word, due.word);
               if (rsp_word_index !== due.index)
                  report_mismatch("word_index", 64'(rsp_word_index), 64'(due.index));
               if (rsp_last !== due.last)
                  report_mismatch("last", 64'(rsp_last), 64'(due.last));
            end
         end
         if (req_valid && !req_stall)
            update_hash(req_kind, req_data_byte);
      end
      words_pending = digest_words_due.size();
   end

endmodule

// File: verif/sha256_stream_hasher_test.sv
// Testbench top for the SHA-256 stream hasher: clock, reset, stimulus, backpressure, verdict.
module sha256_stream_hasher_test;
   import sha_pkg::*;

   localparam logic KIND_FINISH = ~KIND_APPEND;
   localparam int RANDOM_ITEMS = 405;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 16;
   localparam int BOUNDARY_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_kind = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [63:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last;

   int mismatch_count;
   int words_pending;
   int words_checked;
   int items_sent = 0;
   int messages_sent = 0;
   int idle_count = 0;
   bit calm = 1'b0;

   always #4 clock = ~clock;

   sha256_stream_hasher DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last)
   );

   sha256_digest_checker digest_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending),
      .words_checked   (words_checked)
   );

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(15, 0);
   endfunction

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(19, 0);
      if (roll < 12)
         return $urandom_range(12, 0);
      else if (roll < 17)
         return BOUNDARY_LENS[$urandom_range(8, 0)];
      else
         return $urandom_range(130, 0);
   endfunction

   // valid stays high across back-to-back items; only dropped when a gap is drawn
   task automatic send_item(logic kind, logic [7:0] data);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_item(KIND_APPEND, 8'($urandom_range(255, 0)));
      send_item(KIND_FINISH, 8'($urandom_range(255, 0)));
      messages_sent++;
   endtask

   // result side: raise stall ahead of a word and hold it for the drawn gap once a word shows up
   initial begin : rsp_backpressure
      int hold;
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || rsp_stall);
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_count = 0;
         else
            idle_count++;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     idle_count, words_pending);
            $display("sha256_stream_hasher_test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int directed_items;
      int msg_len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty messages back to back (finish byte at both extremes), one-byte messages and 'abc'
      send_item(KIND_FINISH, 8'hff);
      send_item(KIND_FINISH, 8'h00);
      send_item(KIND_APPEND, 8'h00);
      send_item(KIND_FINISH, 8'h5a);
      send_item(KIND_APPEND, 8'hff);
      send_item(KIND_FINISH, 8'hff);
      send_item(KIND_APPEND, 8'h61);
      send_item(KIND_APPEND, 8'h62);
      send_item(KIND_APPEND, 8'h63);
      send_item(KIND_FINISH, 8'h00);
      // bytes that look like padding
      send_item(KIND_APPEND, 8'h80);
      send_item(KIND_APPEND, 8'h7f);
      send_item(KIND_APPEND, 8'h01);
      send_item(KIND_APPEND, 8'hfe);
      send_item(KIND_FINISH, 8'h80);
      messages_sent += 6;
      directed_items = items_sent;

      while (items_sent < directed_items + RANDOM_ITEMS) begin
         calm = ($urandom_range(3, 0) == 0);
         msg_len = pick_length();
         // trim the last message so the run lands on the item budget
         if (msg_len > directed_items + RANDOM_ITEMS - items_sent - 1)
            msg_len = directed_items + RANDOM_ITEMS - items_sent - 1;
         send_message(msg_len);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      @(negedge clock);
      while (words_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items in %0d messages: empty, short, block-boundary and multi-block",
               items_sent, messages_sent);
      $display("%0d digest words compared, %0d mismatches", words_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("sha256_stream_hasher_test passed");
      else
         $display("sha256_stream_hasher_test failed");
      $finish;
   end

endmodule
